>>> rtl/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg: shared definitions for the scan code to ASCII translator
// Scan code constants, keymap lookup functions and the translation record.
// ----------------------------------------------------------------------------
package sc2a_pkg;

	localparam int KEYMAP_ENTRIES_DEF = 64;

	localparam int CODE_W = 8;
	localparam int CHAR_W = 7;

	localparam logic [CODE_W-1:0] BREAK_BIT   = 8'h80;
	localparam logic [CODE_W-1:0] CODE_LSHIFT = 8'h2A;
	localparam logic [CODE_W-1:0] CODE_RSHIFT = 8'h36;
	localparam logic [CODE_W-1:0] CODE_CAPS   = 8'h3A;
	localparam logic [CODE_W-1:0] CODE_LAST_DEAD = 8'h01;

	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7A;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 7'h5A;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [CHAR_W-1:0] char_t;

	// Result of translating one scan code against the current flags.
	typedef struct packed {
		logic  shift_set;
		logic  shift_clr;
		logic  caps_toggle;
		logic  emit;
		char_t ch;
	} xlate_t;

	function automatic char_t lower_char(input logic [CHAR_W-1:0] idx);
		char_t c;
		unique case (idx)
			7'd2:  c = 7'h31;
			7'd3:  c = 7'h32;
			7'd4:  c = 7'h33;
			7'd5:  c = 7'h34;
			7'd6:  c = 7'h35;
			7'd7:  c = 7'h36;
			7'd8:  c = 7'h37;
			7'd9:  c = 7'h38;
			7'd10: c = 7'h39;
			7'd11: c = 7'h30;
			7'd12: c = 7'h2D;
			7'd13: c = 7'h3D;
			7'd14: c = 7'h08;
			7'd15: c = 7'h09;
			7'd16: c = 7'h71;
			7'd17: c = 7'h77;
			7'd18: c = 7'h65;
			7'd19: c = 7'h72;
			7'd20: c = 7'h74;
			7'd21: c = 7'h79;
			7'd22: c = 7'h75;
			7'd23: c = 7'h69;
			7'd24: c = 7'h6F;
			7'd25: c = 7'h70;
			7'd26: c = 7'h5B;
			7'd27: c = 7'h5D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h61;
			7'd31: c = 7'h73;
			7'd32: c = 7'h64;
			7'd33: c = 7'h66;
			7'd34: c = 7'h67;
			7'd35: c = 7'h68;
			7'd36: c = 7'h6A;
			7'd37: c = 7'h6B;
			7'd38: c = 7'h6C;
			7'd39: c = 7'h3B;
			7'd40: c = 7'h27;
			7'd41: c = 7'h60;
			7'd43: c = 7'h5C;
			7'd44: c = 7'h7A;
			7'd45: c = 7'h78;
			7'd46: c = 7'h63;
			7'd47: c = 7'h76;
			7'd48: c = 7'h62;
			7'd49: c = 7'h6E;
			7'd50: c = 7'h6D;
			7'd51: c = 7'h2C;
			7'd52: c = 7'h2E;
			7'd53: c = 7'h2F;
			7'd55: c = 7'h2A;
			7'd57: c = 7'h20;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic char_t upper_char(input logic [CHAR_W-1:0] idx);
		char_t c;
		unique case (idx)
			7'd2:  c = 7'h21;
			7'd3:  c = 7'h40;
			7'd4:  c = 7'h23;
			7'd5:  c = 7'h24;
			7'd6:  c = 7'h25;
			7'd7:  c = 7'h5E;
			7'd8:  c = 7'h26;
			7'd9:  c = 7'h2A;
			7'd10: c = 7'h28;
			7'd11: c = 7'h29;
			7'd12: c = 7'h5F;
			7'd13: c = 7'h2B;
			7'd14: c = 7'h08;
			7'd15: c = 7'h09;
			7'd16: c = 7'h51;
			7'd17: c = 7'h57;
			7'd18: c = 7'h45;
			7'd19: c = 7'h52;
			7'd20: c = 7'h54;
			7'd21: c = 7'h59;
			7'd22: c = 7'h55;
			7'd23: c = 7'h49;
			7'd24: c = 7'h4F;
			7'd25: c = 7'h50;
			7'd26: c = 7'h7B;
			7'd27: c = 7'h7D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h41;
			7'd31: c = 7'h53;
			7'd32: c = 7'h44;
			7'd33: c = 7'h46;
			7'd34: c = 7'h47;
			7'd35: c = 7'h48;
			7'd36: c = 7'h4A;
			7'd37: c = 7'h4B;
			7'd38: c = 7'h4C;
			7'd39: c = 7'h3A;
			7'd40: c = 7'h22;
			7'd41: c = 7'h7E;
			7'd43: c = 7'h7C;
			7'd44: c = 7'h5A;
			7'd45: c = 7'h58;
			7'd46: c = 7'h43;
			7'd47: c = 7'h56;
			7'd48: c = 7'h42;
			7'd49: c = 7'h4E;
			7'd50: c = 7'h4D;
			7'd51: c = 7'h3C;
			7'd52: c = 7'h3E;
			7'd53: c = 7'h3F;
			7'd55: c = 7'h2A;
			7'd57: c = 7'h20;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic is_letter(input char_t c);
		return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
		       ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z));
	endfunction

endpackage

>>> rtl/sc2a_code_if.sv
// ----------------------------------------------------------------------------
// sc2a_code_if: scan code channel
// Valid/ready channel that carries one raw scan code byte per transaction.
// ----------------------------------------------------------------------------
interface sc2a_code_if;
	logic                 valid;
	logic                 ready;
	logic [sc2a_pkg::CODE_W-1:0] scan_code;

	modport source (output valid, output scan_code, input ready);
	modport sink (input valid, input scan_code, output ready);
endinterface

>>> rtl/sc2a_char_if.sv
// ----------------------------------------------------------------------------
// sc2a_char_if: character channel
// Valid/ready channel that carries one ASCII character per transaction.
// ----------------------------------------------------------------------------
interface sc2a_char_if;
	logic                 valid;
	logic                 ready;
	logic [sc2a_pkg::CHAR_W-1:0] ascii_char;

	modport source (output valid, output ascii_char, input ready);
	modport sink (input valid, input ascii_char, output ready);
endinterface

>>> rtl/sc2a_keymap.sv
// ----------------------------------------------------------------------------
// sc2a_keymap: scan code translation
// Decodes modifier codes and looks up the keymap under the current flags.
// ----------------------------------------------------------------------------
module sc2a_keymap #(
	parameter int KEYMAP_ENTRIES = sc2a_pkg::KEYMAP_ENTRIES_DEF
) (
	input  sc2a_pkg::code_t  code,
	input  logic             shift_held,
	input  logic             caps_on,
	output sc2a_pkg::xlate_t xl
);

	logic                          is_shift_make;
	logic                          is_shift_break;
	logic                          is_caps_make;
	logic                          in_map;
	logic [sc2a_pkg::CHAR_W-1:0]   idx;
	sc2a_pkg::char_t               low;
	sc2a_pkg::char_t               high;
	logic                          use_upper;

	assign is_shift_make  = (code == sc2a_pkg::CODE_LSHIFT) || (code == sc2a_pkg::CODE_RSHIFT);
	assign is_shift_break = (code == (sc2a_pkg::CODE_LSHIFT | sc2a_pkg::BREAK_BIT)) ||
	                        (code == (sc2a_pkg::CODE_RSHIFT | sc2a_pkg::BREAK_BIT));
	assign is_caps_make   = (code == sc2a_pkg::CODE_CAPS);

	// Break codes, the two dead codes and codes past the keymap give nothing
	assign in_map = ((code & sc2a_pkg::BREAK_BIT) == '0) &&
	                ({1'b0, code} < 9'(KEYMAP_ENTRIES)) &&
	                (code > sc2a_pkg::CODE_LAST_DEAD);

	assign idx  = code[sc2a_pkg::CHAR_W-1:0];
	assign low  = sc2a_pkg::lower_char(idx);
	assign high = sc2a_pkg::upper_char(idx);

	// Caps lock only affects letters
	assign use_upper = sc2a_pkg::is_letter(low) ? (shift_held ^ caps_on) : shift_held;

	always_comb begin
		xl.shift_set   = is_shift_make;
		xl.shift_clr   = is_shift_break;
		xl.caps_toggle = is_caps_make;
		xl.ch          = use_upper ? high : low;
		xl.emit        = in_map && !is_shift_make && !is_caps_make && (xl.ch != '0);
	end

endmodule

>>> rtl/sc2a_outreg.sv
// ----------------------------------------------------------------------------
// sc2a_outreg: result register
// Holds one translated character until the receiver takes it.
// ----------------------------------------------------------------------------
module sc2a_outreg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  sc2a_pkg::char_t      load_char,
	output logic                 free,
	sc2a_char_if.source          chars
);

	logic            valid_q;
	sc2a_pkg::char_t char_q;

	assign free = !valid_q || chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= load_char;
		end
	end

	assign chars.valid      = valid_q;
	assign chars.ascii_char = char_q;

endmodule

>>> rtl/scancode_to_ascii.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii: set 1 keyboard scan code to ASCII translator
// Tracks shift and caps lock and turns make codes into ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   keys  : sink channel, one raw scan code byte per transaction. Bit 7 set
//           marks a key release.
//   chars : source channel, one ASCII character per transaction. Codes that
//           give no character (modifiers, releases, unmapped keys) produce
//           no transaction at all.
// Path: input register, then translation logic, then result register.
// Throughput: one scan code per cycle unless chars stalls. The input register
//   and the result register are parted by the translation logic; the input
//   register drains whenever the result register is empty or being taken in
//   the same cycle.
// Stall: while chars is stalled with a character waiting, one more scan code
//   is held in the input register and keys.ready drops until the result
//   register frees up. Nothing is lost or repeated.
// Reset: arst_n clears both pipeline valids, the shift-held flag and the
//   caps lock flag (shift released, caps lock off).
// ----------------------------------------------------------------------------
module scancode_to_ascii #(
	parameter int KEYMAP_ENTRIES = sc2a_pkg::KEYMAP_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sc2a_code_if.sink   keys,
	sc2a_char_if.source chars
);

	// Input register stage
	logic             valid_s1;
	sc2a_pkg::code_t  code_s1;

	// Modifier flags, updated as each scan code leaves the input stage
	logic             shift_held_q;
	logic             caps_on_q;

	sc2a_pkg::xlate_t xl;
	logic             out_free;
	logic             advance;

	// Advance the input stage whenever the result register can take a value;
	// items without a result simply retire in that cycle.
	assign advance    = valid_s1 && out_free;
	assign keys.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (keys.ready) begin
			valid_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			code_s1 <= keys.scan_code;
		end
	end

	sc2a_keymap #(
		.KEYMAP_ENTRIES (KEYMAP_ENTRIES)
	) u_keymap (
		.code       (code_s1),
		.shift_held (shift_held_q),
		.caps_on    (caps_on_q),
		.xl         (xl)
	);

	// Flags change only when the scan code that drives them retires, so the
	// next code always sees the state left by this one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_held_q <= 1'b0;
			caps_on_q    <= 1'b0;
		end else if (advance) begin
			if (xl.shift_set) begin
				shift_held_q <= 1'b1;
			end else if (xl.shift_clr) begin
				shift_held_q <= 1'b0;
			end
			if (xl.caps_toggle) begin
				caps_on_q <= !caps_on_q;
			end
		end
	end

	sc2a_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && xl.emit),
		.load_char (xl.ch),
		.free      (out_free),
		.chars     (chars)
	);

endmodule
